// ----- sv/gn3_pkg.sv -----
// Shared types, constants and tables for the 3D gradient noise unit.
// Holds the permutation table, the edge gradient table and a rounding multiply.
// No dependencies.
package gn3_pkg;

   // Gradient component codes: zero, plus one, minus one.
   localparam logic [1:0] G_ZERO = 2'b00;
   localparam logic [1:0] G_POS  = 2'b01;
   localparam logic [1:0] G_NEG  = 2'b11;

   typedef struct packed {
      logic [1:0] gx;
      logic [1:0] gy;
      logic [1:0] gz;
   } grad_type;

   localparam logic [7:0] PERM [256] = '{
      8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
      8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,
      8'd8,8'd99,8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,
      8'd234,8'd75,8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,
      8'd35,8'd11,8'd32,8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,
      8'd20,8'd125,8'd136,8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,
      8'd134,8'd139,8'd48,8'd27,8'd166,8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,
      8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,8'd220,8'd105,8'd92,8'd41,
      8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,8'd65,8'd25,8'd63,8'd161,
      8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,8'd208,8'd89,
      8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,8'd164,
      8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,
      8'd250,8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,
      8'd85,8'd212,8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,
      8'd189,8'd28,8'd42,8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,
      8'd44,8'd154,8'd163,8'd70,8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,
      8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,
      8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,8'd218,8'd246,8'd97,
      8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,8'd191,8'd179,
      8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,
      8'd107,8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,
      8'd204,8'd176,8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,
      8'd138,8'd236,8'd205,8'd93,8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,
      8'd141,8'd128,8'd195,8'd78,8'd66,8'd215,8'd61,8'd156,8'd180
   };

   function automatic logic [7:0] perm_at(input logic [7:0] idx);
      return PERM[idx];
   endfunction

   // Hash mod 12 through a reciprocal multiply; exact for all 8-bit hashes.
   function automatic logic [3:0] hash_mod12(input logic [7:0] h);
      logic [15:0] prod;
      logic [7:0]  rem;
      prod = 16'(h) * 16'd171;
      rem  = h - (8'(prod[15:11]) * 8'd12);
      return rem[3:0];
   endfunction

   function automatic grad_type grad_of(input logic [3:0] id);
      grad_type g;
      case (id)
         4'd0:    g = '{G_POS,  G_POS,  G_ZERO};
         4'd1:    g = '{G_NEG,  G_POS,  G_ZERO};
         4'd2:    g = '{G_POS,  G_NEG,  G_ZERO};
         4'd3:    g = '{G_NEG,  G_NEG,  G_ZERO};
         4'd4:    g = '{G_POS,  G_ZERO, G_POS};
         4'd5:    g = '{G_NEG,  G_ZERO, G_POS};
         4'd6:    g = '{G_POS,  G_ZERO, G_NEG};
         4'd7:    g = '{G_NEG,  G_ZERO, G_NEG};
         4'd8:    g = '{G_ZERO, G_POS,  G_POS};
         4'd9:    g = '{G_ZERO, G_NEG,  G_POS};
         4'd10:   g = '{G_ZERO, G_POS,  G_NEG};
         4'd11:   g = '{G_ZERO, G_NEG,  G_NEG};
         default: g = '{G_ZERO, G_ZERO, G_ZERO};
      endcase
      return g;
   endfunction

   // Fixed-point product rounded to frac fraction bits, ties away from zero.
   function automatic logic signed [31:0] round_mul(input logic signed [31:0] a,
                                                    input logic signed [31:0] b,
                                                    input int frac);
      logic signed [63:0] p;
      logic [63:0]        mag;
      logic [63:0]        r;
      p   = 64'(a) * 64'(b);
      mag = p[63] ? 64'(-p) : 64'(p);
      r   = (mag + (64'd1 << (frac - 1))) >> frac;
      return p[63] ? -32'(r) : 32'(r);
   endfunction

endpackage

// ----- sv/gn3_fifo.sv -----
// Small first-word-fall-through queue held in registers.
// Used between the front and back parts and on the result side. No dependencies.
module gn3_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign rdata = mem_ff[rd_ff];

   assign wr_in  = !push ? wr_ff : (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
   assign rd_in  = !pop  ? rd_ff : (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
   assign cnt_in = cnt_ff + CW'(push) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end
endmodule

// ----- sv/gn3_front.sv -----
// Front part: splits the point into cells and fractions, hashes the eight
// corners and computes the three fade weights. Depends on gn3_pkg.
module gn3_front #(
   parameter int FRAC_BITS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [31:0]            px,
   input  logic [31:0]            py,
   input  logic [31:0]            pz,
   output logic                   out_valid,
   output logic [6*FRAC_BITS+66:0] out_data
);
   import gn3_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int FW = F + 6;
   localparam logic signed [FW-1:0] ONE     = FW'(1) << F;
   localparam logic signed [FW-1:0] FIFTEEN = FW'(15) << F;
   localparam logic signed [FW-1:0] TEN     = FW'(10) << F;

   logic [31:0] p [3];
   assign p[0] = px;
   assign p[1] = py;
   assign p[2] = pz;

   // Stage 0: cells and fractions.
   logic         v0_ff;
   logic [7:0]   c0_ff [3], c0_in [3];
   logic [F-1:0] f0_ff [3], f0_in [3];
   // Stage 1: first hash level, t*t and 6t-15.
   logic                 v1_ff;
   logic [7:0]           c1_ff [2];
   logic [7:0]           hz1_ff [2], hz1_in [2];
   logic signed [FW-1:0] tt1_ff [3], tt1_in [3], s1_ff [3], s1_in [3];
   logic [F-1:0]         f1_ff [3];
   // Stage 2: second hash level, cube and inner polynomial.
   logic                 v2_ff;
   logic [7:0]           cx2_ff;
   logic [7:0]           hyz2_ff [4], hyz2_in [4];
   logic signed [FW-1:0] cube2_ff [3], cube2_in [3], inner2_ff [3], inner2_in [3];
   logic [F-1:0]         f2_ff [3];
   // Stage 3: corner hashes and clamped fades.
   logic                 v3_ff;
   logic [7:0]           h3_ff [8], h3_in [8];
   logic [F:0]           fade3_ff [3], fade3_in [3];
   logic [F-1:0]         f3_ff [3];

   always_comb begin
      logic signed [FW-1:0] t;
      logic signed [FW-1:0] r;
      for (int a = 0; a < 3; a++) begin
         c0_in[a] = p[a][F+7:F];
         f0_in[a] = p[a][F-1:0];
         t = FW'(f1_ff[a]);
         t = FW'(f0_ff[a]);
         tt1_in[a] = FW'(round_mul(32'(t), 32'(t), F));
         s1_in[a]  = (t <<< 2) + (t <<< 1) - FIFTEEN;
         t = FW'(f1_ff[a]);
         cube2_in[a]  = FW'(round_mul(32'(tt1_ff[a]), 32'(t), F));
         inner2_in[a] = FW'(round_mul(32'(t), 32'(s1_ff[a]), F)) + TEN;
         r = FW'(round_mul(32'(cube2_ff[a]), 32'(inner2_ff[a]), F));
         if (r < 0) begin
            fade3_in[a] = '0;
         end else if (r > ONE) begin
            fade3_in[a] = ONE[F:0];
         end else begin
            fade3_in[a] = r[F:0];
         end
      end
      for (int k = 0; k < 2; k++) begin
         hz1_in[k] = perm_at(c0_ff[2] + 8'(k));
      end
      for (int j = 0; j < 2; j++) begin
         for (int k = 0; k < 2; k++) begin
            hyz2_in[j*2+k] = perm_at(c1_ff[1] + 8'(j) + hz1_ff[k]);
         end
      end
      for (int i = 0; i < 2; i++) begin
         for (int m = 0; m < 4; m++) begin
            h3_in[i*4+m] = perm_at(cx2_ff + 8'(i) + hyz2_ff[m]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      c0_ff    <= c0_in;
      f0_ff    <= f0_in;
      c1_ff[0] <= c0_ff[0];
      c1_ff[1] <= c0_ff[1];
      hz1_ff   <= hz1_in;
      tt1_ff   <= tt1_in;
      s1_ff    <= s1_in;
      f1_ff    <= f0_ff;
      cx2_ff   <= c1_ff[0];
      hyz2_ff  <= hyz2_in;
      cube2_ff <= cube2_in;
      inner2_ff <= inner2_in;
      f2_ff    <= f1_ff;
      h3_ff    <= h3_in;
      fade3_ff <= fade3_in;
      f3_ff    <= f2_ff;
   end

   assign out_valid = v3_ff;
   assign out_data  = {h3_ff[7], h3_ff[6], h3_ff[5], h3_ff[4],
                       h3_ff[3], h3_ff[2], h3_ff[1], h3_ff[0],
                       f3_ff[2], f3_ff[1], f3_ff[0],
                       fade3_ff[2], fade3_ff[1], fade3_ff[0]};
endmodule

// ----- sv/gn3_back.sv -----
// Back part: gradient dot products, trilinear blend and mapping to [0,1].
// Depends on gn3_pkg.
module gn3_back #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic [6*FRAC_BITS+66:0] in_data,
   output logic                    out_valid,
   output logic [16:0]             out_level
);
   import gn3_pkg::*;

   localparam int F  = FRAC_BITS;
   localparam int FW = F + 6;
   localparam int LW = FW + 17;
   localparam logic signed [FW-1:0] ONE = FW'(1) << F;

   logic [7:0]   h [8];
   logic [F-1:0] f [3];
   logic [F:0]   fade [3];

   always_comb begin
      for (int c = 0; c < 8; c++) begin
         h[c] = in_data[6*F+3+8*c +: 8];
      end
      for (int a = 0; a < 3; a++) begin
         f[a]    = in_data[3*F+3+F*a +: F];
         fade[a] = in_data[(F+1)*a +: F+1];
      end
   end

   logic [7:0] v_ff, v_in;

   logic signed [FW-1:0] d0_ff [8], d0_in [8];
   logic [F:0]           u_ff [1], vw_ff [3], w_ff [5];
   logic signed [FW-1:0] a1_ff [4], m1_ff [4], m1_in [4];
   logic signed [FW-1:0] x2_ff [4], x2_in [4];
   logic signed [FW-1:0] a3_ff [2], m3_ff [2], m3_in [2];
   logic signed [FW-1:0] y4_ff [2], y4_in [2];
   logic signed [FW-1:0] a5_ff, m5_ff, m5_in;
   logic signed [FW-1:0] n6_ff, n6_in;
   logic [16:0]          lvl7_ff, lvl7_in;

   function automatic logic signed [FW-1:0] term(input logic [1:0] g,
                                                 input logic signed [FW-1:0] d);
      case (g)
         G_POS:   return d;
         G_NEG:   return -d;
         default: return '0;
      endcase
   endfunction

   always_comb begin
      grad_type             g;
      logic signed [FW-1:0] dx, dy, dz, val;
      logic [LW-1:0]        wide;
      for (int i = 0; i < 2; i++) begin
         for (int j = 0; j < 2; j++) begin
            for (int k = 0; k < 2; k++) begin
               g  = grad_of(hash_mod12(h[i*4+j*2+k]));
               dx = FW'(f[0]) - (i == 1 ? ONE : '0);
               dy = FW'(f[1]) - (j == 1 ? ONE : '0);
               dz = FW'(f[2]) - (k == 1 ? ONE : '0);
               d0_in[i*4+j*2+k] = term(g.gx, dx) + term(g.gy, dy) + term(g.gz, dz);
            end
         end
      end
      // Blend along x: corner pairs differ in the x offset.
      for (int m = 0; m < 4; m++) begin
         m1_in[m] = FW'(round_mul(32'(FW'(u_ff[0])), 32'(d0_ff[4+m] - d0_ff[m]), F));
         x2_in[m] = a1_ff[m] + m1_ff[m];
      end
      for (int k = 0; k < 2; k++) begin
         m3_in[k] = FW'(round_mul(32'(FW'(vw_ff[2])), 32'(x2_ff[2+k] - x2_ff[k]), F));
         y4_in[k] = a3_ff[k] + m3_ff[k];
      end
      m5_in = FW'(round_mul(32'(FW'(w_ff[4])), 32'(y4_ff[1] - y4_ff[0]), F));
      n6_in = a5_ff + m5_ff;
      val = n6_ff + ONE;
      if (val < 0) begin
         val = '0;
      end
      wide = ((LW'(val) << 16) + LW'(ONE)) >> (F + 1);
      lvl7_in = (wide > LW'(65536)) ? 17'd65536 : wide[16:0];
   end

   assign v_in = {v_ff[6:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   // Fade weights ride along until their blend level is reached.
   always_ff @(posedge clock) begin
      d0_ff    <= d0_in;
      u_ff[0]  <= fade[0];
      vw_ff[0] <= fade[1];
      w_ff[0]  <= fade[2];
      vw_ff[1] <= vw_ff[0];
      vw_ff[2] <= vw_ff[1];
      for (int s = 1; s < 5; s++) begin
         w_ff[s] <= w_ff[s-1];
      end
      a1_ff    <= d0_ff[0:3];
      m1_ff    <= m1_in;
      x2_ff    <= x2_in;
      a3_ff    <= x2_ff[0:1];
      m3_ff    <= m3_in;
      y4_ff    <= y4_in;
      a5_ff    <= y4_ff[0];
      m5_ff    <= m5_in;
      n6_ff    <= n6_in;
      lvl7_ff  <= lvl7_in;
   end

   assign out_valid = v_ff[7];
   assign out_level = lvl7_ff;
endmodule

// ----- sv/gradient_noise_3d_unit.sv -----
// Top level of the 3D gradient noise unit: front part, middle queue, back part
// and result queue. Depends on gn3_pkg, gn3_front, gn3_fifo and gn3_back.
//
// One point in signed fixed point goes in per cycle while full is low, and one
// noise level in unsigned Q1.16 comes out per point, in order. A point passes
// through the front pipeline (cell hash through the permutation table, fade
// polynomial), may wait in the middle queue, then runs through the back
// pipeline (dot products, three blend levels of a multiply and an add each,
// output mapping) and is written into the result queue.
// Full rises only when the middle queue's credits (MID_DEPTH) run out; the back
// part stops pulling from it when the result queue's credits (OUT_DEPTH) are
// taken by results in the back pipeline or waiting in the result queue.
module gradient_noise_3d_unit #(
   parameter int FRAC_BITS = 16,
   parameter int MID_DEPTH = 8,
   parameter int OUT_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [31:0] req_px,
   input  logic [31:0] req_py,
   input  logic [31:0] req_pz,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [16:0] rsp_level
);
   localparam int IW = 6 * FRAC_BITS + 67;
   localparam int MW = $clog2(MID_DEPTH + 1);
   localparam int OW = $clog2(OUT_DEPTH + 1);

   logic          accept, mid_pop, rsp_take;
   logic          front_valid, mid_empty, back_valid;
   logic [IW-1:0] front_data, mid_data;
   logic [16:0]   back_level;
   logic [MW-1:0] front_cnt_ff, front_cnt_in;
   logic [OW-1:0] back_cnt_ff, back_cnt_in;

   assign req_full = (front_cnt_ff == MW'(MID_DEPTH));
   assign accept   = req_push & ~req_full;
   assign mid_pop  = ~mid_empty & (back_cnt_ff != OW'(OUT_DEPTH));
   assign rsp_take = rsp_pop & ~rsp_empty;

   // Credits: beats in the front pipeline or the middle queue, and beats in
   // the back pipeline or the result queue.
   assign front_cnt_in = front_cnt_ff + MW'(accept) - MW'(mid_pop);
   assign back_cnt_in  = back_cnt_ff + OW'(mid_pop) - OW'(rsp_take);

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
      end else begin
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
      end
   end

   gn3_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock(clock), .reset(reset), .in_valid(accept),
      .px(req_px), .py(req_py), .pz(req_pz),
      .out_valid(front_valid), .out_data(front_data)
   );

   gn3_fifo #(.WIDTH(IW), .DEPTH(MID_DEPTH)) u_mid (
      .clock(clock), .reset(reset), .push(front_valid), .wdata(front_data),
      .pop(mid_pop), .rdata(mid_data), .empty(mid_empty)
   );

   gn3_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock(clock), .reset(reset), .in_valid(mid_pop), .in_data(mid_data),
      .out_valid(back_valid), .out_level(back_level)
   );

   gn3_fifo #(.WIDTH(17), .DEPTH(OUT_DEPTH)) u_out (
      .clock(clock), .reset(reset), .push(back_valid), .wdata(back_level),
      .pop(rsp_take), .rdata(rsp_level), .empty(rsp_empty)
   );
endmodule

// ----- sv/gn3_checker.sv -----
// Port-level checks for the 3D gradient noise unit, bound to the top level.
// Depends on gradient_noise_3d_unit.
module gn3_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_full,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [16:0] rsp_level
);
   // Reset leaves the block with room for input and no results.
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (!req_full && rsp_empty))
      else $error("block not clear after reset");

   // A level never exceeds one.
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_level <= 17'd65536))
      else $error("level out of range");

   // A waiting result that is not taken stays put.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_level)))
      else $error("waiting result changed");

   // No result can be waiting in the first cycle after reset is released.
   a_no_early: assert property (@(posedge clock)
      (!reset && $past(reset)) |-> rsp_empty)
      else $error("result right after reset");
endmodule

bind gradient_noise_3d_unit gn3_checker u_gn3_checker (
   .clock(clock), .reset(reset), .req_full(req_full),
   .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_level(rsp_level)
);
